[sv/lbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache package
// Sizes, register indexes and sequencer states used by the cache core.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int ENTRIES = 64;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int KEY_W  = 64;
   localparam int TIME_W = 64;
   localparam int CAP_W  = 7;
   localparam int IDLE_W = 16;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam int NS_W  = 30;
   localparam int LIM_W = IDLE_W + NS_W;
   localparam logic [NS_W-1:0] NS_PER_SECOND = NS_W'(1000000000);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT = 1'b1;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_CHECK,
      ST_EXPIRE,
      ST_UPDATE,
      ST_DONE
   } lbc_state_type;

endpackage

[sv/lru_block_cache_with_idle_expiry_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU block cache directory with idle expiry
// Fully associative LRU directory of 64-bit block keys with victim reporting.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and returns one response word for
// each. Keys, last-use times and recency ranks live in three memories that are
// swept one entry per cycle: one sweep searches for the key, the free slot and
// the least recent entry, and for a hit or an insert a second sweep rewrites the
// recency ranks. An insert that evicts passes an idle check between the two
// sweeps, and a lookup miss skips the second sweep. Valid bits are flip-flops
// cleared by reset, so the block is ready right after reset. A new request is
// accepted while the previous response still waits on the output.
// ----------------------------------------------------------------------------
module lru_block_cache_with_idle_expiry_core (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [lbc_pkg::KEY_W-1:0]      req_key,
   input  logic [lbc_pkg::TIME_W-1:0]     req_now_time,
   input  logic                           req_batch_end,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic                           rsp_victim_valid,
   output logic [lbc_pkg::KEY_W-1:0]      rsp_victim_key,
   output logic                           rsp_victim_dropped,
   output logic                           rsp_batch_end_out,

   input  logic                           csr_write,
   input  logic [lbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import lbc_pkg::*;

   lbc_state_type state_ff, state_in;

   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [IDLE_W-1:0]  idle_ff, idle_in;
   logic [LIM_W-1:0]   lim_ns_ff, lim_ns_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   sweep_ff, sweep_in;
   logic               pipe_vld_ff, pipe_vld_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               mode_ff, mode_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic               bend_ff, bend_in;
   logic [IDX_W-1:0]   pipe_idx_ff, pipe_idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [IDX_W-1:0]   found_rank_ff, found_rank_in;
   logic               free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]   vic_idx_ff, vic_idx_in;
   logic [KEY_W-1:0]   vic_key_ff, vic_key_in;
   logic [TIME_W-1:0]  vic_last_ff, vic_last_in;
   logic [IDX_W-1:0]   tgt_idx_ff, tgt_idx_in;
   logic               ins_ff, ins_in;
   logic               res_hit_ff, res_hit_in;
   logic               res_vvalid_ff, res_vvalid_in;
   logic               res_vdrop_ff, res_vdrop_in;
   logic [TIME_W-1:0]  diff_ff, diff_in;
   logic               back_ff, back_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic               rsp_vvalid_ff, rsp_vvalid_in;
   logic [KEY_W-1:0]   rsp_vkey_ff, rsp_vkey_in;
   logic               rsp_vdrop_ff, rsp_vdrop_in;
   logic               rsp_bend_ff, rsp_bend_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   key_rd;
   logic [TIME_W-1:0]  last_rd;
   logic [IDX_W-1:0]   rank_rd;
   logic               tgt_we;
   logic               rank_we;
   logic [IDX_W-1:0]   rank_wdata;

   logic               sweep_last;
   logic               ent_valid;
   logic [CNT_W-1:0]   count_m1;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   eff_cap;
   logic               full;
   logic               evict;
   logic [IDX_W-1:0]   slot;

   lbc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (pipe_idx_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lbc_ram #(.WIDTH(TIME_W), .DEPTH(ENTRIES)) u_last_ram (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (pipe_idx_ff),
      .wr_data (now_ff),
      .rd_addr (rd_addr),
      .rd_data (last_rd)
   );

   lbc_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_rank_ram (
      .clock   (clock),
      .wr_en   (rank_we),
      .wr_addr (pipe_idx_ff),
      .wr_data (rank_wdata),
      .rd_addr (rd_addr),
      .rd_data (rank_rd)
   );

   assign sweep_last = (sweep_ff == CNT_W'(ENTRIES));
   assign rd_addr    = sweep_last ? '0 : sweep_ff[IDX_W-1:0];
   assign ent_valid  = valid_ff[pipe_idx_ff];
   assign count_m1   = count_ff - CNT_W'(1);
   assign cap_ext    = CMP_W'(cap_ff);
   assign eff_cap    = (cap_ff == '0) ? CMP_W'(1) :
                       (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
   assign full       = (CMP_W'(count_ff) >= eff_cap);
   assign evict      = full || !free_ok_ff;
   assign slot       = free_ok_ff ? free_idx_ff : vic_idx_ff;

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      idle_in       = idle_ff;
      lim_ns_in     = LIM_W'(idle_ff) * LIM_W'(NS_PER_SECOND);
      valid_in      = valid_ff;
      count_in      = count_ff;
      sweep_in      = sweep_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = sweep_ff[IDX_W-1:0];
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      bend_in       = bend_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_rank_in = found_rank_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      vic_idx_in    = vic_idx_ff;
      vic_key_in    = vic_key_ff;
      vic_last_in   = vic_last_ff;
      tgt_idx_in    = tgt_idx_ff;
      ins_in        = ins_ff;
      res_hit_in    = res_hit_ff;
      res_vvalid_in = res_vvalid_ff;
      res_vdrop_in  = res_vdrop_ff;
      diff_in       = diff_ff;
      back_in       = back_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_vvalid_in = rsp_vvalid_ff;
      rsp_vkey_in   = rsp_vkey_ff;
      rsp_vdrop_in  = rsp_vdrop_ff;
      rsp_bend_in   = rsp_bend_ff;
      tgt_we        = 1'b0;
      rank_we       = 1'b0;
      rank_wdata    = '0;

      if (csr_write) begin
         unique case (csr_index)
            CSR_CAPACITY:   cap_in  = csr_wdata[CAP_W-1:0];
            CSR_IDLE_LIMIT: idle_in = csr_wdata[IDLE_W-1:0];
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (state_ff == ST_SEARCH || state_ff == ST_UPDATE) begin
         pipe_vld_in = !sweep_last;
         sweep_in    = sweep_last ? '0 : sweep_ff + CNT_W'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in       = req_mode;
               key_in        = req_key;
               now_in        = req_now_time;
               bend_in       = req_batch_end;
               found_in      = 1'b0;
               free_ok_in    = 1'b0;
               res_hit_in    = 1'b0;
               res_vvalid_in = 1'b0;
               res_vdrop_in  = 1'b0;
               sweep_in      = '0;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (pipe_vld_ff) begin
               if (ent_valid && key_rd == key_ff) begin
                  found_in      = 1'b1;
                  found_idx_in  = pipe_idx_ff;
                  found_rank_in = rank_rd;
               end
               if (ent_valid && rank_rd == count_m1[IDX_W-1:0]) begin
                  vic_idx_in  = pipe_idx_ff;
                  vic_key_in  = key_rd;
                  vic_last_in = last_rd;
               end
               if (!ent_valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = pipe_idx_ff;
               end
            end
            if (sweep_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (found_ff) begin
               res_hit_in = 1'b1;
               tgt_idx_in = found_idx_ff;
               ins_in     = 1'b0;
               state_in   = ST_UPDATE;
            end else if (!mode_ff) begin
               state_in = ST_DONE;
            end else begin
               ins_in     = 1'b1;
               tgt_idx_in = slot;
               if (evict) begin
                  res_vvalid_in         = 1'b1;
                  valid_in[vic_idx_ff]  = 1'b0;
                  diff_in               = now_ff - vic_last_ff;
                  back_in               = (now_ff < vic_last_ff);
                  state_in              = ST_EXPIRE;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  state_in = ST_UPDATE;
               end
               valid_in[slot] = 1'b1;
            end
         end
         ST_EXPIRE: begin
            res_vdrop_in = (idle_ff != '0) && !back_ff &&
                           (diff_ff >= TIME_W'(lim_ns_ff));
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (pipe_vld_ff) begin
               if (pipe_idx_ff == tgt_idx_ff) begin
                  tgt_we     = 1'b1;
                  rank_we    = 1'b1;
                  rank_wdata = '0;
               end else if (ent_valid && (ins_ff || rank_rd < found_rank_ff)) begin
                  rank_we    = 1'b1;
                  rank_wdata = rank_rd + IDX_W'(1);
               end
            end
            if (sweep_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_vvalid_in = res_vvalid_ff;
               rsp_vkey_in   = res_vvalid_ff ? vic_key_ff : '0;
               rsp_vdrop_in  = res_vdrop_ff;
               rsp_bend_in   = bend_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         idle_ff      <= '0;
         lim_ns_ff    <= '0;
         valid_ff     <= '0;
         count_ff     <= '0;
         sweep_ff     <= '0;
         pipe_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         idle_ff      <= idle_in;
         lim_ns_ff    <= lim_ns_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         pipe_vld_ff  <= pipe_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      bend_ff       <= bend_in;
      pipe_idx_ff   <= pipe_idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_rank_ff <= found_rank_in;
      free_ok_ff    <= free_ok_in;
      free_idx_ff   <= free_idx_in;
      vic_idx_ff    <= vic_idx_in;
      vic_key_ff    <= vic_key_in;
      vic_last_ff   <= vic_last_in;
      tgt_idx_ff    <= tgt_idx_in;
      ins_ff        <= ins_in;
      res_hit_ff    <= res_hit_in;
      res_vvalid_ff <= res_vvalid_in;
      res_vdrop_ff  <= res_vdrop_in;
      diff_ff       <= diff_in;
      back_ff       <= back_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_vvalid_ff <= rsp_vvalid_in;
      rsp_vkey_ff   <= rsp_vkey_in;
      rsp_vdrop_ff  <= rsp_vdrop_in;
      rsp_bend_ff   <= rsp_bend_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_victim_valid   = rsp_vvalid_ff;
   assign rsp_victim_key     = rsp_vkey_ff;
   assign rsp_victim_dropped = rsp_vdrop_ff;
   assign rsp_batch_end_out  = rsp_bend_ff;

endmodule

[sv/lbc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
